>>> src/pce_pkg.sv
package pce_pkg;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_TIMEOUT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_INCREMENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MAX       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_INITIAL   = 3'd5;

  // Register values after reset
  localparam logic [31:0] RST_CONNECT_TIMEOUT  = 32'd5000;
  localparam logic [31:0] RST_PEER_TIMEOUT     = 32'd10000;
  localparam logic [31:0] RST_PING_INTERVAL    = 32'd1000;
  localparam logic [15:0] RST_WINDOW_INCREMENT = 16'd1;
  localparam logic [15:0] RST_WINDOW_MAX       = 16'd64;
  localparam logic [15:0] RST_WINDOW_INITIAL   = 16'd4;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_CONNECT,
    OP_DISCONNECT,
    OP_PACKET
  } opcode_t;

  typedef enum logic [3:0] {
    PT_PING          = 4'd0,
    PT_PONG          = 4'd1,
    PT_ACK           = 4'd2,
    PT_CONN_REQ      = 4'd3,
    PT_CONN_RESP     = 4'd4,
    PT_CONN_ACK      = 4'd5,
    PT_CONN_COMPLETE = 4'd6,
    PT_DISC_NOTIFY   = 4'd7,
    PT_USER_DATA     = 4'd8,
    PT_OTHER         = 4'd9
  } pkt_type_t;

  typedef enum logic [2:0] {
    LS_DISC,
    LS_REQ,
    LS_RESP,
    LS_ACKD,
    LS_CONN
  } link_state_t;

  typedef enum logic [1:0] {
    BK_EXEC,
    BK_RTT_MAG,
    BK_RTT_AVG,
    BK_RTT_DEV
  } back_state_t;

  // Peer event codes
  localparam logic [2:0] EV_CONNECTED    = 3'd0;
  localparam logic [2:0] EV_DISCONNECTED = 3'd1;
  localparam logic [2:0] EV_UNABLE       = 3'd2;
  localparam logic [2:0] EV_TIMED_OUT    = 3'd3;
  localparam logic [2:0] EV_RECEIVED     = 3'd4;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  typedef struct packed {
    logic [31:0] connect_timeout;
    logic [31:0] peer_timeout;
    logic [31:0] ping_interval;
    logic [15:0] window_increment;
    logic [15:0] window_max;
    logic [15:0] window_initial;
  } cfg_t;

  // Classified item held between front and back
  typedef struct packed {
    opcode_t     op;
    logic [63:0] now;
    pkt_type_t   ptype;
    logic        rel;
    logic        ord;
    logic [7:0]  ch;
    logic [31:0] seq;
    logic [63:0] stamp;
    logic        flag;
    logic        clean;
    logic [63:0] sent_time;
    logic        need_ack;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  code;
    logic        rel;
    logic        imm;
    logic [31:0] seq;
    logic [63:0] stamp;
    logic        ok;
    logic        has_ch;
    logic [7:0]  ch;
    logic        last;
  } result_t;

  function automatic result_t mk_pkt(input pkt_type_t ptype, input logic rel,
                                     input logic imm, input logic [31:0] seq,
                                     input logic [63:0] stamp, input logic ok,
                                     input logic has_ch, input logic [7:0] ch);
    result_t r;
    r.kind   = KIND_PACKET;
    r.code   = 3'(ptype);
    r.rel    = rel;
    r.imm    = imm;
    r.seq    = seq;
    r.stamp  = stamp;
    r.ok     = ok;
    r.has_ch = has_ch;
    r.ch     = has_ch ? ch : 8'd0;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_evt(input logic [2:0] code);
    result_t r;
    r      = '0;
    r.kind = KIND_EVENT;
    r.code = code;
    return r;
  endfunction

endpackage

>>> src/pce_in_if.sv
interface pce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] now;
  logic [3:0]  packet_type;
  logic        reliable_flag;
  logic        ordered_flag;
  logic [7:0]  rx_channel;
  logic [31:0] header_seq;
  logic [31:0] payload_seq;
  logic [63:0] payload_stamp;
  logic        payload_flag;
  logic        acked_clean;
  logic [63:0] acked_send_time;

  modport source (
    output valid, opcode, now, packet_type, reliable_flag, ordered_flag, rx_channel,
           header_seq, payload_seq, payload_stamp, payload_flag, acked_clean,
           acked_send_time,
    input  ready
  );

  modport sink (
    input  valid, opcode, now, packet_type, reliable_flag, ordered_flag, rx_channel,
           header_seq, payload_seq, payload_stamp, payload_flag, acked_clean,
           acked_send_time,
    output ready
  );
endinterface

>>> src/pce_out_if.sv
interface pce_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  out_code;
  logic        out_reliable;
  logic        out_immediate;
  logic [31:0] out_seq;
  logic [63:0] out_stamp;
  logic        out_ok;
  logic        out_has_channel;
  logic [7:0]  out_channel;
  logic        last_result;

  modport source (
    output valid, result_kind, out_code, out_reliable, out_immediate, out_seq,
           out_stamp, out_ok, out_has_channel, out_channel, last_result,
    input  ready
  );

  modport sink (
    input  valid, result_kind, out_code, out_reliable, out_immediate, out_seq,
           out_stamp, out_ok, out_has_channel, out_channel, last_result,
    output ready
  );
endinterface

>>> src/pce_cfg_if.sv
interface pce_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pce_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/peer_connection_engine.sv
// An item passes the input queue; its results pass the result buffer and the output
// register, a second result following the first. The engine takes one item per cycle
// while the output accepts results; an item that takes an RTT sample (clean ack, pong
// while connected) holds the engine through the RTT magnitude, average and deviation
// states; an item with two results holds back the next. Reset (rst_n low, synchronous):
// registers to defaults, link disconnected, congestion window 4, queues empty.
module peer_connection_engine (
  input  logic       clk,
  input  logic       rst_n,
  pce_in_if.sink     in_chan,
  pce_out_if.source  out_chan,
  pce_cfg_if.sink    cfg_chan
);

  pce_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           q_valid;
  logic           q_pop;
  pce_pkg::item_t q_item;

  assign cfg_chan.ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        pce_pkg::CFG_CONNECT_TIMEOUT:  cfg_nxt.connect_timeout  = cfg_chan.data;
        pce_pkg::CFG_PEER_TIMEOUT:     cfg_nxt.peer_timeout     = cfg_chan.data;
        pce_pkg::CFG_PING_INTERVAL:    cfg_nxt.ping_interval    = cfg_chan.data;
        pce_pkg::CFG_WINDOW_INCREMENT: cfg_nxt.window_increment = cfg_chan.data[15:0];
        pce_pkg::CFG_WINDOW_MAX:       cfg_nxt.window_max       = cfg_chan.data[15:0];
        pce_pkg::CFG_WINDOW_INITIAL:   cfg_nxt.window_initial   = cfg_chan.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connect_timeout  <= pce_pkg::RST_CONNECT_TIMEOUT;
      cfg_r.peer_timeout     <= pce_pkg::RST_PEER_TIMEOUT;
      cfg_r.ping_interval    <= pce_pkg::RST_PING_INTERVAL;
      cfg_r.window_increment <= pce_pkg::RST_WINDOW_INCREMENT;
      cfg_r.window_max       <= pce_pkg::RST_WINDOW_MAX;
      cfg_r.window_initial   <= pce_pkg::RST_WINDOW_INITIAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pce_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pce_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

>>> src/pce_front.sv
module pce_front (
  input  logic            clk,
  input  logic            rst_n,
  pce_in_if.sink          in_chan,
  output logic            q_valid,
  output pce_pkg::item_t  q_item,
  input  logic            q_pop
);

  pce_pkg::item_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  pce_pkg::item_t item_in;

  // Accept while the queue has a free slot
  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;

  // Classify: fold unknown packet types, flag packets that need an ack
  always_comb begin
    item_in.op        = pce_pkg::opcode_t'(in_chan.opcode);
    item_in.now       = in_chan.now;
    item_in.ptype     = (in_chan.packet_type > 4'd9) ? pce_pkg::PT_OTHER
                                                     : pce_pkg::pkt_type_t'(in_chan.packet_type);
    item_in.rel       = in_chan.reliable_flag;
    item_in.ord       = in_chan.ordered_flag;
    item_in.ch        = in_chan.rx_channel;
    item_in.seq       = in_chan.header_seq;
    item_in.stamp     = in_chan.payload_stamp;
    item_in.flag      = in_chan.payload_flag;
    item_in.clean     = in_chan.acked_clean;
    item_in.sent_time = in_chan.acked_send_time;
    item_in.need_ack  = (item_in.op == pce_pkg::OP_PACKET) && in_chan.reliable_flag &&
                        (item_in.ptype >= pce_pkg::PT_CONN_COMPLETE);
  end

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    case ({push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rd_ptr_r];

endmodule

>>> src/pce_back.sv
module pce_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pce_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  pce_pkg::item_t  q_item,
  output logic            q_pop,
  pce_out_if.source       out_chan
);

  pce_pkg::back_state_t state_r, state_nxt;
  pce_pkg::link_state_t link_r, link_nxt;
  logic                 incoming_r, incoming_nxt;
  logic [63:0]          connect_time_r, connect_time_nxt;
  logic [63:0]          last_recv_r, last_recv_nxt;
  logic [63:0]          last_ping_r, last_ping_nxt;
  logic [63:0]          last_sample_r, last_sample_nxt;
  logic [63:0]          rtt_avg_r, rtt_avg_nxt;
  logic [63:0]          rtt_dev_r, rtt_dev_nxt;
  logic [15:0]          cwnd_r, cwnd_nxt;

  // RTT sample datapath
  logic [63:0]          meas_r, meas_nxt;
  logic [63:0]          mag_r, mag_nxt;
  logic                 mag_neg_r, mag_neg_nxt;
  logic [63:0]          dev_diff_r, dev_diff_nxt;
  logic                 dev_up_r, dev_up_nxt;

  // Result buffer and output register
  pce_pkg::result_t     res0_r, res0_nxt;
  pce_pkg::result_t     res1_r, res1_nxt;
  logic [1:0]           res_cnt_r, res_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pce_pkg::result_t     out_pl_r, out_pl_nxt;

  pce_pkg::item_t       it;
  logic [63:0]          d_conn, d_recv, d_samp, d_ping, meas;
  logic                 conn_to, recv_to, samp_due, ping_due;
  logic [16:0]          wsum;
  logic [15:0]          wcap;
  logic                 move, res_free;
  logic                 m0_v, m1_v, do_reset, rtt_go;
  pce_pkg::result_t     ack_res, m0, m1, r0, r1;
  logic [1:0]           n_res;
  logic [63:0]          diff_up, diff_dn;

  assign it = q_item;

  // Time differences against the stored stamps
  assign d_conn   = it.now - connect_time_r;
  assign d_recv   = it.now - last_recv_r;
  assign d_samp   = it.now - last_sample_r;
  assign d_ping   = it.now - last_ping_r;
  assign conn_to  = d_conn > {32'd0, cfg.connect_timeout};
  assign recv_to  = d_recv > {32'd0, cfg.peer_timeout};
  assign samp_due = d_samp > {32'd0, cfg.ping_interval};
  assign ping_due = d_ping > {32'd0, cfg.ping_interval};
  assign meas     = it.now - ((it.ptype == pce_pkg::PT_ACK) ? it.sent_time : it.stamp);

  // Window growth, capped
  assign wsum = {1'b0, cwnd_r} + {1'b0, cfg.window_increment};
  assign wcap = (wsum > {1'b0, cfg.window_max}) ? cfg.window_max : wsum[15:0];

  // Drain the result buffer into the output register
  assign move     = (res_cnt_r != 2'd0) && (!out_valid_r || out_chan.ready);
  assign res_free = (res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && move);
  assign q_pop    = (state_r == pce_pkg::BK_EXEC) && q_valid && res_free;

  assign diff_up = meas_r - rtt_avg_r;
  assign diff_dn = rtt_avg_r - meas_r;

  // Engine: next state and results
  always_comb begin
    state_nxt        = state_r;
    link_nxt         = link_r;
    incoming_nxt     = incoming_r;
    connect_time_nxt = connect_time_r;
    last_recv_nxt    = last_recv_r;
    last_ping_nxt    = last_ping_r;
    last_sample_nxt  = last_sample_r;
    rtt_avg_nxt      = rtt_avg_r;
    rtt_dev_nxt      = rtt_dev_r;
    cwnd_nxt         = cwnd_r;
    meas_nxt         = meas_r;
    mag_nxt          = mag_r;
    mag_neg_nxt      = mag_neg_r;
    dev_diff_nxt     = dev_diff_r;
    dev_up_nxt       = dev_up_r;
    m0_v             = 1'b0;
    m1_v             = 1'b0;
    m0               = '0;
    m1               = '0;
    do_reset         = 1'b0;
    rtt_go           = 1'b0;
    ack_res          = pce_pkg::mk_pkt(pce_pkg::PT_ACK, 1'b0, 1'b1, it.seq, 64'd0, 1'b0,
                                       it.ord, it.ch);

    unique case (state_r)
      pce_pkg::BK_EXEC: begin
        if (q_pop) begin
          unique case (it.op)
            pce_pkg::OP_TICK: begin
              unique case (link_r) inside
                pce_pkg::LS_REQ, pce_pkg::LS_RESP, pce_pkg::LS_ACKD: begin
                  if (conn_to) begin
                    m0_v     = !incoming_r;
                    m0       = pce_pkg::mk_evt(pce_pkg::EV_UNABLE);
                    do_reset = 1'b1;
                  end
                end
                pce_pkg::LS_CONN: begin
                  if (recv_to) begin
                    m0_v     = 1'b1;
                    m0       = pce_pkg::mk_evt(pce_pkg::EV_TIMED_OUT);
                    do_reset = 1'b1;
                  end else if (samp_due && ping_due) begin
                    m0_v          = 1'b1;
                    m0            = pce_pkg::mk_pkt(pce_pkg::PT_PING, 1'b0, 1'b1, 32'd0,
                                                    it.now, 1'b0, 1'b0, 8'd0);
                    last_ping_nxt = it.now;
                  end
                end
                default: ;
              endcase
            end
            pce_pkg::OP_CONNECT: begin
              if (link_r == pce_pkg::LS_DISC) begin
                link_nxt         = pce_pkg::LS_REQ;
                connect_time_nxt = it.now;
                m0_v             = 1'b1;
                m0               = pce_pkg::mk_pkt(pce_pkg::PT_CONN_REQ, 1'b1, 1'b1, 32'd0,
                                                   64'd0, 1'b0, 1'b0, 8'd0);
              end
            end
            pce_pkg::OP_DISCONNECT: begin
              if (link_r == pce_pkg::LS_CONN) begin
                m0_v = 1'b1;
                m0   = pce_pkg::mk_pkt(pce_pkg::PT_DISC_NOTIFY, 1'b1, 1'b1, 32'd0,
                                       64'd0, 1'b0, 1'b0, 8'd0);
              end
            end
            pce_pkg::OP_PACKET: begin
              last_recv_nxt = it.now;
              case (it.ptype)
                pce_pkg::PT_PING: begin
                  if (link_r == pce_pkg::LS_CONN) begin
                    last_ping_nxt = it.now;
                    m0_v          = 1'b1;
                    m0            = pce_pkg::mk_pkt(pce_pkg::PT_PONG, 1'b0, 1'b1, 32'd0,
                                                    it.stamp, 1'b0, 1'b0, 8'd0);
                  end
                end
                pce_pkg::PT_PONG: begin
                  rtt_go = (link_r == pce_pkg::LS_CONN);
                end
                pce_pkg::PT_ACK: begin
                  if (it.clean) begin
                    rtt_go   = 1'b1;
                    cwnd_nxt = wcap;
                  end
                end
                pce_pkg::PT_CONN_REQ: begin
                  if (link_r == pce_pkg::LS_DISC) begin
                    link_nxt         = pce_pkg::LS_RESP;
                    incoming_nxt     = 1'b1;
                    connect_time_nxt = it.now;
                    m0_v             = 1'b1;
                    m0               = pce_pkg::mk_pkt(pce_pkg::PT_CONN_RESP, 1'b1, 1'b0,
                                                       it.seq, 64'd0, 1'b1, 1'b0, 8'd0);
                  end
                end
                pce_pkg::PT_CONN_RESP: begin
                  if (link_r == pce_pkg::LS_REQ) begin
                    rtt_avg_nxt     = d_conn;
                    last_sample_nxt = it.now;
                    if (!it.flag) begin
                      link_nxt = pce_pkg::LS_DISC;
                    end else begin
                      link_nxt = pce_pkg::LS_ACKD;
                      m0_v     = 1'b1;
                      m0       = pce_pkg::mk_pkt(pce_pkg::PT_CONN_ACK, 1'b1, 1'b1, it.seq,
                                                 64'd0, 1'b0, 1'b0, 8'd0);
                    end
                  end
                end
                pce_pkg::PT_CONN_ACK: begin
                  if (link_r == pce_pkg::LS_RESP) begin
                    rtt_avg_nxt     = d_conn;
                    last_sample_nxt = it.now;
                    link_nxt        = pce_pkg::LS_CONN;
                    m0_v            = 1'b1;
                    m0              = pce_pkg::mk_pkt(pce_pkg::PT_CONN_COMPLETE, 1'b1, 1'b1,
                                                      it.seq, 64'd0, 1'b0, 1'b0, 8'd0);
                    m1_v            = 1'b1;
                    m1              = pce_pkg::mk_evt(pce_pkg::EV_CONNECTED);
                  end
                end
                pce_pkg::PT_CONN_COMPLETE: begin
                  if (link_r == pce_pkg::LS_ACKD) begin
                    link_nxt = pce_pkg::LS_CONN;
                    m0_v     = 1'b1;
                    m0       = pce_pkg::mk_evt(pce_pkg::EV_CONNECTED);
                  end
                end
                pce_pkg::PT_DISC_NOTIFY: begin
                  if (link_r == pce_pkg::LS_CONN) begin
                    do_reset = 1'b1;
                    m0_v     = 1'b1;
                    m0       = pce_pkg::mk_evt(pce_pkg::EV_DISCONNECTED);
                  end
                end
                pce_pkg::PT_USER_DATA: begin
                  if ((link_r == pce_pkg::LS_CONN) && it.flag) begin
                    m0_v = 1'b1;
                    m0   = pce_pkg::mk_evt(pce_pkg::EV_RECEIVED);
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase

          // Start an RTT sample
          if (rtt_go) begin
            meas_nxt        = meas;
            last_sample_nxt = it.now;
            state_nxt       = pce_pkg::BK_RTT_MAG;
          end

          // Peer reset overrides every other state update
          if (do_reset) begin
            link_nxt         = pce_pkg::LS_DISC;
            incoming_nxt     = 1'b0;
            connect_time_nxt = 64'd0;
            last_recv_nxt    = 64'd0;
            last_ping_nxt    = 64'd0;
            last_sample_nxt  = 64'd0;
            rtt_avg_nxt      = 64'd0;
            rtt_dev_nxt      = 64'd0;
            cwnd_nxt         = cfg.window_initial;
          end
        end
      end
      pce_pkg::BK_RTT_MAG: begin
        mag_neg_nxt = meas_r < rtt_avg_r;
        mag_nxt     = (meas_r < rtt_avg_r) ? diff_dn : diff_up;
        state_nxt   = pce_pkg::BK_RTT_AVG;
      end
      pce_pkg::BK_RTT_AVG: begin
        rtt_avg_nxt  = mag_neg_r ? (rtt_avg_r - (mag_r >> 3)) : (rtt_avg_r + (mag_r >> 3));
        dev_up_nxt   = mag_r >= rtt_dev_r;
        dev_diff_nxt = (mag_r >= rtt_dev_r) ? (mag_r - rtt_dev_r) : (rtt_dev_r - mag_r);
        state_nxt    = pce_pkg::BK_RTT_DEV;
      end
      pce_pkg::BK_RTT_DEV: begin
        rtt_dev_nxt = dev_up_r ? (rtt_dev_r + (dev_diff_r >> 2))
                               : (rtt_dev_r - (dev_diff_r >> 2));
        state_nxt   = pce_pkg::BK_EXEC;
      end
      default: state_nxt = pce_pkg::BK_EXEC;
    endcase
  end

  // Order results: ack first, then handler results; mark the last one
  always_comb begin
    if (ack_res.kind == pce_pkg::KIND_PACKET && it.need_ack) begin
      r0 = ack_res;
      r1 = m0;
    end else begin
      r0 = m0;
      r1 = m1;
    end
    n_res = {1'b0, it.need_ack} + {1'b0, m0_v} + {1'b0, m1_v};
    if (n_res == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  // Load or drain the result buffer, feed the output register
  always_comb begin
    res0_nxt      = res0_r;
    res1_nxt      = res1_r;
    res_cnt_nxt   = res_cnt_r;
    out_pl_nxt    = out_pl_r;
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_pl_nxt    = res0_r;
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      res0_nxt    = r0;
      res1_nxt    = r1;
      res_cnt_nxt = n_res;
    end else if (move) begin
      res0_nxt    = res1_r;
      res_cnt_nxt = res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pce_pkg::BK_EXEC;
      link_r         <= pce_pkg::LS_DISC;
      incoming_r     <= 1'b0;
      connect_time_r <= 64'd0;
      last_recv_r    <= 64'd0;
      last_ping_r    <= 64'd0;
      last_sample_r  <= 64'd0;
      rtt_avg_r      <= 64'd0;
      rtt_dev_r      <= 64'd0;
      cwnd_r         <= pce_pkg::RST_WINDOW_INITIAL;
      res_cnt_r      <= 2'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      link_r         <= link_nxt;
      incoming_r     <= incoming_nxt;
      connect_time_r <= connect_time_nxt;
      last_recv_r    <= last_recv_nxt;
      last_ping_r    <= last_ping_nxt;
      last_sample_r  <= last_sample_nxt;
      rtt_avg_r      <= rtt_avg_nxt;
      rtt_dev_r      <= rtt_dev_nxt;
      cwnd_r         <= cwnd_nxt;
      res_cnt_r      <= res_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    meas_r     <= meas_nxt;
    mag_r      <= mag_nxt;
    mag_neg_r  <= mag_neg_nxt;
    dev_diff_r <= dev_diff_nxt;
    dev_up_r   <= dev_up_nxt;
    res0_r     <= res0_nxt;
    res1_r     <= res1_nxt;
    out_pl_r   <= out_pl_nxt;
  end

  // Drive the result channel
  assign out_chan.valid           = out_valid_r;
  assign out_chan.result_kind     = out_pl_r.kind;
  assign out_chan.out_code        = out_pl_r.code;
  assign out_chan.out_reliable    = out_pl_r.rel;
  assign out_chan.out_immediate   = out_pl_r.imm;
  assign out_chan.out_seq         = out_pl_r.seq;
  assign out_chan.out_stamp       = out_pl_r.stamp;
  assign out_chan.out_ok          = out_pl_r.ok;
  assign out_chan.out_has_channel = out_pl_r.has_ch;
  assign out_chan.out_channel     = out_pl_r.ch;
  assign out_chan.last_result     = out_pl_r.last;

endmodule
